@@ rtl/core/tbll_pkg.sv @@
// ----------------------------------------------------------------------------
// tbll_pkg
// Shared types and constants for the token-bucket log limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package tbll_pkg;

	// register map
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 14;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_REFILL  = 2'd0,
		REG_CAP     = 2'd1,
		REG_RELEASE = 2'd2,
		REG_COST    = 2'd3
	} cfg_reg_t;

	localparam int REFILL_BITS  = 10;
	localparam int CAP_BITS     = 14;
	localparam int RELEASE_BITS = 14;
	localparam int COST_BITS    = 10;

	localparam logic [REFILL_BITS-1:0]  REFILL_RST  = 10'd1;
	localparam logic [CAP_BITS-1:0]     CAP_RST     = 14'd300;
	localparam logic [RELEASE_BITS-1:0] RELEASE_RST = 14'd100;
	localparam logic [COST_BITS-1:0]    COST_RST    = 10'd10;

	// credit in tenths of a message
	localparam int CREDIT_BITS = 16;
	localparam int LEVEL_BITS  = 15;

	// elapsed seconds beyond this width saturate, filling the bucket to the cap unless refill is zero
	localparam int ELAP_BITS = 15;

	localparam int TS_BITS       = 32;
	localparam int TIME_BITS_DEF = 32;

	localparam int OUT_BITS  = 2 + LEVEL_BITS;
	localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

	typedef struct packed {
		logic [REFILL_BITS-1:0]  refill_per_second;
		logic [CAP_BITS-1:0]     burst_cap;
		logic [RELEASE_BITS-1:0] release_level;
		logic [COST_BITS-1:0]    message_cost;
	} cfg_t;

	typedef struct packed {
		logic                           forward;
		logic                           warn;
		logic signed [CREDIT_BITS-1:0] credit;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/core/token_bucket_log_limiter_top.sv @@
// ----------------------------------------------------------------------------
// token_bucket_log_limiter_top
// Token-bucket limiter for timestamped message events.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tdata[31:0] timestamp
//  m_*       out  m_tvalid/m_tready    tdata[0] forward, [1] warn,
//                                      [16:2] credit_level, [23:17] zero
//  cfg_*     in   cfg_we               cfg_index selects register, cfg_data
//
//  One item per clock sustained while m_tready stays high. The path runs
//  through the input register, then the bucket update feeding the result
//  register. Credit state updates in the same cycle it is read, which is what
//  sets the one-item rate. arst_n clears both pipeline stages, the bucket
//  (full, 300 tenths) and the config registers. A stall on m_tready backs
//  up through the input register only once the result register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module token_bucket_log_limiter_top #(
	parameter int TIME_BITS = tbll_pkg::TIME_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// slave side
	input  wire logic                                 s_tvalid,
	output      logic                                 s_tready,
	input  wire logic [tbll_pkg::TS_BITS-1:0]        s_tdata,   // [31:0] timestamp
	// master side
	output      logic                                 m_tvalid,
	input  wire logic                                 m_tready,
	output      logic [8*tbll_pkg::OUT_BYTES-1:0]    m_tdata,   // forward, warn, credit_level
	// config
	input  wire logic                                 cfg_we,
	input  wire logic [tbll_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [tbll_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import tbll_pkg::*;

	cfg_t                  cfg;
	res_t                  res;

	logic                  valid_s1;
	logic [TS_BITS-1:0]    ts_s1;
	logic                  valid_s2;
	logic                  forward_s2;
	logic                  warn_s2;
	logic [LEVEL_BITS-1:0] level_s2;

	logic                  out_free;
	logic                  adv;

	tbll_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// result register frees up when empty or being taken this cycle
	assign out_free = !valid_s2 || m_tready;
	assign adv      = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			ts_s1 <= s_tdata;
	end

	tbll_update #(
		.TIME_BITS (TIME_BITS)
	) u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (adv),
		.timestamp (ts_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (out_free)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			forward_s2 <= res.forward;
			warn_s2    <= res.warn;
			level_s2   <= res.credit[LEVEL_BITS-1:0];
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(8*OUT_BYTES-OUT_BITS){1'b0}}, level_s2, warn_s2, forward_s2};

	// a fresh warning never forwards unless release is at zero
	a_warn_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.warn && (cfg.release_level != '0) |-> !res.forward)
		else $error("warning event forwarded");

	// credit never falls below one full message cost under zero
	a_credit_floor: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> (res.credit >= -16'sd1023))
		else $error("credit underflow");

	// an item leaving stage one always lands in the result register
	a_adv_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("item lost between stages");

	// empty result register never blocks the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("input stalled with free result register");

endmodule

`default_nettype wire

@@ rtl/core/tbll_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tbll_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
`default_nettype none

module tbll_cfg_regs (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [tbll_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [tbll_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output tbll_pkg::cfg_t                            cfg
);
	import tbll_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.refill_per_second <= REFILL_RST;
			cfg_q.burst_cap         <= CAP_RST;
			cfg_q.release_level     <= RELEASE_RST;
			cfg_q.message_cost      <= COST_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_REFILL:  cfg_q.refill_per_second <= cfg_data[REFILL_BITS-1:0];
				REG_CAP:     cfg_q.burst_cap         <= cfg_data[CAP_BITS-1:0];
				REG_RELEASE: cfg_q.release_level     <= cfg_data[RELEASE_BITS-1:0];
				REG_COST:    cfg_q.message_cost      <= cfg_data[COST_BITS-1:0];
				default:     ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/tbll_update.sv @@
// ----------------------------------------------------------------------------
// tbll_update
// Bucket state and the combinational refill / clamp / penalty / spend logic.
// ----------------------------------------------------------------------------
`default_nettype none

module tbll_update #(
	parameter int TIME_BITS = tbll_pkg::TIME_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire tbll_pkg::cfg_t                 cfg,
	input  wire logic                           step,
	input  wire logic [tbll_pkg::TS_BITS-1:0] timestamp,
	output tbll_pkg::res_t                      res
);
	import tbll_pkg::*;

	localparam int SUM_BITS = ELAP_BITS + REFILL_BITS + 2;

	logic signed [CREDIT_BITS-1:0] credit_q;
	logic [TIME_BITS-1:0]          last_time_q;
	logic                          seen_first_q;
	logic                          silenced_q;

	logic [TIME_BITS-1:0]          now;
	logic [TIME_BITS:0]            diff;
	logic [ELAP_BITS-1:0]          elapsed;
	logic [ELAP_BITS+REFILL_BITS-1:0] prod;
	logic signed [SUM_BITS-1:0]    sum;
	logic                          over_cap;
	logic signed [CREDIT_BITS-1:0] c_pre;
	logic signed [CREDIT_BITS-1:0] c_post;
	logic                          empty;
	logic                          at_release;
	logic                          silenced_d;

	generate
		if (TIME_BITS > TS_BITS) begin : g_wide
			assign now = {{(TIME_BITS-TS_BITS){1'b0}}, timestamp};
		end else begin : g_narrow
			assign now = timestamp[TIME_BITS-1:0];
		end
	endgenerate

	always_comb begin
		diff = {1'b0, now} - {1'b0, last_time_q};
		// backward step counts as none, long gaps saturate
		if (diff[TIME_BITS])
			elapsed = '0;
		else if (|diff[TIME_BITS-1:ELAP_BITS])
			elapsed = '1;
		else
			elapsed = diff[ELAP_BITS-1:0];

		prod     = (ELAP_BITS+REFILL_BITS)'(elapsed) *
		           (ELAP_BITS+REFILL_BITS)'(cfg.refill_per_second);
		sum      = {{(SUM_BITS-CREDIT_BITS){credit_q[CREDIT_BITS-1]}}, credit_q} +
		           $signed({2'b00, prod});
		over_cap = sum > $signed({{(SUM_BITS-CAP_BITS){1'b0}}, cfg.burst_cap});

		if (!seen_first_q)
			c_pre = credit_q;
		else if (over_cap)
			c_pre = $signed({{(CREDIT_BITS-CAP_BITS){1'b0}}, cfg.burst_cap});
		else
			c_pre = sum[CREDIT_BITS-1:0];

		empty      = c_pre[CREDIT_BITS-1] || (c_pre == '0);
		at_release = c_pre >= $signed({{(CREDIT_BITS-RELEASE_BITS){1'b0}},
		                               cfg.release_level});
		silenced_d = (silenced_q || empty) && !at_release;

		c_post = silenced_d ? c_pre
		                    : c_pre - $signed({{(CREDIT_BITS-COST_BITS){1'b0}},
		                                       cfg.message_cost});

		res.forward = !silenced_d;
		res.warn    = empty && !silenced_q;
		res.credit  = c_post;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q     <= $signed({{(CREDIT_BITS-CAP_BITS){1'b0}}, CAP_RST});
			last_time_q  <= '0;
			seen_first_q <= 1'b0;
			silenced_q   <= 1'b0;
		end else if (step) begin
			credit_q     <= c_post;
			last_time_q  <= now;
			seen_first_q <= 1'b1;
			silenced_q   <= silenced_d;
		end
	end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for token_bucket_log_limiter_top. A table of hand-picked
// events covers the edges of the credit logic (first event, backward and huge
// time steps, penalty entry and release, zero cost, zero and lowered caps).
// Several phases of random timestamps under random register settings then
// follow. Results are checked against typed row values or an in-bench bucket model.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import tbll_pkg::*;

	// drill table and random run sizing
	localparam int DRILL_ROWS  = 29;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 118;
	localparam int FAULT_PRINTS = 40;

	// one result item, laid out as on m_tdata from bit 0 up
	typedef struct packed {
		logic [LEVEL_BITS-1:0] credit_level;
		logic                  warn;
		logic                  forward;
	} verdict_t;

	typedef enum logic {
		STEP_EVENT,
		STEP_WRITE
	} drill_step_t;

	// arg is the timestamp of an event, or the value of a register write.
	// want is only used where typed is set.
	typedef struct packed {
		drill_step_t kind;
		cfg_reg_t    sel;
		logic [31:0] arg;
		logic        typed;
		verdict_t    want;
	} drill_row_t;

	// Walked top to bottom. Each write waits for the block to drain first.
	// Comments give the credit seen by the event before any cost.
	localparam drill_row_t DRILL [DRILL_ROWS] = '{
		// first event after reset: no refill, full bucket of 300
		'{STEP_EVENT, REG_REFILL, 32'd0,          1'b1, '{15'd290, 1'b0, 1'b1}},
		// huge forward jump refills straight to the cap
		'{STEP_EVENT, REG_REFILL, 32'hFFFF_FFFF,  1'b1, '{15'd290, 1'b0, 1'b1}},
		// backward step counts as no time at all
		'{STEP_EVENT, REG_REFILL, 32'd0,          1'b1, '{15'd280, 1'b0, 1'b1}},
		// top bits of the write are dropped, cost becomes 1023
		'{STEP_WRITE, REG_COST,   32'h3FFF,       1'b0, '0},
		'{STEP_EVENT, REG_REFILL, 32'd0,          1'b1, '{-15'sd743, 1'b0, 1'b1}},
		// credit below zero: warn once, then stay silent
		'{STEP_EVENT, REG_REFILL, 32'd0,          1'b1, '{-15'sd743, 1'b1, 1'b0}},
		'{STEP_EVENT, REG_REFILL, 32'd0,          1'b1, '{-15'sd743, 1'b0, 1'b0}},
		'{STEP_WRITE, REG_REFILL, 32'h3FFF,       1'b0, '0},
		// one second at 1023 lifts credit to 280, above release: let through
		'{STEP_EVENT, REG_REFILL, 32'd1,          1'b1, '{-15'sd743, 1'b0, 1'b1}},
		'{STEP_WRITE, REG_RELEASE, 32'd0,         1'b0, '0},
		'{STEP_WRITE, REG_COST,   32'd0,          1'b0, '0},
		'{STEP_EVENT, REG_REFILL, 32'd1,          1'b1, '{-15'sd743, 1'b1, 1'b0}},
		'{STEP_WRITE, REG_REFILL, 32'd743,        1'b0, '0},
		// credit exactly zero while silenced: released, no fresh warning
		'{STEP_EVENT, REG_REFILL, 32'd2,          1'b1, '{15'd0, 1'b0, 1'b1}},
		// zero again, not silenced: warning and release in the same event
		'{STEP_EVENT, REG_REFILL, 32'd2,          1'b1, '{15'd0, 1'b1, 1'b1}},
		// zero cap pins the credit at zero
		'{STEP_WRITE, REG_CAP,    32'd0,          1'b0, '0},
		'{STEP_EVENT, REG_REFILL, 32'd3,          1'b1, '{15'd0, 1'b1, 1'b1}},
		'{STEP_WRITE, REG_CAP,    32'h3FFF,       1'b0, '0},
		'{STEP_WRITE, REG_RELEASE, 32'h3FFF,      1'b0, '0},
		'{STEP_WRITE, REG_REFILL, 32'd1000,       1'b0, '0},
		// highest credit the level field carries
		'{STEP_EVENT, REG_REFILL, 32'hFFFF_FFFF,  1'b1, '{15'd16383, 1'b0, 1'b1}},
		'{STEP_WRITE, REG_COST,   32'd1000,       1'b0, '0},
		'{STEP_EVENT, REG_REFILL, 32'hFFFF_FFFF,  1'b1, '{15'd15383, 1'b0, 1'b1}},
		// cap lowered under the held credit: clamped down on the next event
		'{STEP_WRITE, REG_CAP,    32'd1,          1'b0, '0},
		'{STEP_EVENT, REG_REFILL, 32'hFFFF_FFFF,  1'b1, '{-15'sd999, 1'b0, 1'b1}},
		'{STEP_EVENT, REG_REFILL, 32'd0,          1'b1, '{-15'sd999, 1'b1, 1'b0}},
		// positive credit under a release level it cannot reach: stays silent
		'{STEP_EVENT, REG_REFILL, 32'hAAAA_AAAA,  1'b0, '0},
		'{STEP_EVENT, REG_REFILL, 32'h5555_5555,  1'b0, '0},
		'{STEP_EVENT, REG_REFILL, 32'h5555_5556,  1'b0, '0}
	};

	// ---------------------------------------------------------------- DUT
	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      s_tvalid  = 1'b0;
	logic                      s_tready;
	logic [TS_BITS-1:0]        s_tdata   = '0;
	logic                      m_tvalid;
	logic                      m_tready  = 1'b0;
	logic [8*OUT_BYTES-1:0]    m_tdata;
	logic                      cfg_we    = 1'b0;
	cfg_reg_t                  cfg_index = REG_REFILL;
	logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

	token_bucket_log_limiter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// hard stop, far beyond the slowest correct run
	initial begin
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// ---------------------------------------------------------- bucket model
	// register copies, updated as each write lands
	logic [REFILL_BITS-1:0]  cfg_refill  = REFILL_RST;
	logic [CAP_BITS-1:0]     cfg_cap     = CAP_RST;
	logic [RELEASE_BITS-1:0] cfg_release = RELEASE_RST;
	logic [COST_BITS-1:0]    cfg_cost    = COST_RST;

	// bucket state as the block should hold it
	longint      bkt_credit  = 300;
	logic [31:0] bkt_last    = '0;
	logic        bkt_started = 1'b0;
	logic        bkt_muted   = 1'b0;

	verdict_t awaited_verdicts [$];

	int  faults       = 0;
	int  items_sent   = 0;
	int  results_seen = 0;
	bit  tx_steady    = 1'b0;
	bit  rx_steady    = 1'b0;
	logic [31:0] wall = '0;

	// Runs one event through the bucket and returns what the block must emit.
	function automatic verdict_t bucket_update(input logic [31:0] stamp);
		longint   lvl;
		longint   gain;
		longint   refill_l;
		longint   cap_l;
		longint   rel_l;
		longint   cost_l;
		verdict_t v;
		refill_l = cfg_refill;
		cap_l    = cfg_cap;
		rel_l    = cfg_release;
		cost_l   = cfg_cost;
		lvl      = bkt_credit;
		v        = '0;
		// first event only records the time
		if (bkt_started) begin
			gain = 0;
			if (stamp >= bkt_last)
				gain = stamp - bkt_last;
			// at most 2^32 s times 1023, so no overflow in 64 bits
			lvl = lvl + gain * refill_l;
			if (lvl > cap_l)
				lvl = cap_l;
		end
		bkt_started = 1'b1;
		bkt_last    = stamp;
		if (lvl <= 0) begin
			v.warn    = !bkt_muted;
			bkt_muted = 1'b1;
		end
		// checked after entry, so a zero release level frees a credit of exactly zero at once
		if (lvl >= rel_l)
			bkt_muted = 1'b0;
		v.forward = !bkt_muted;
		if (v.forward)
			lvl = lvl - cost_l;
		bkt_credit     = lvl;
		v.credit_level = lvl[LEVEL_BITS-1:0];
		return v;
	endfunction

	function automatic void check_field(input string what, input longint want,
	                                    input longint got);
		if (want != got) begin
			faults++;
			if (faults <= FAULT_PRINTS)
				$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	// --------------------------------------------------------------- drivers
	// All tasks start and return on a falling edge.

	// Offers one item after a random gap and predicts its result on acceptance.
	// tvalid is left high so a gap-free follower needs no extra edge.
	task automatic send_stamp(input logic [31:0] stamp, input logic typed,
	                          input verdict_t typed_want);
		int       gap;
		verdict_t predicted;
		if ($urandom_range(0, 31) == 0)
			tx_steady = !tx_steady;
		gap = tx_steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= stamp;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = bucket_update(stamp);
		awaited_verdicts.push_back(typed ? typed_want : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	// Withdraws tvalid and holds until every awaited result is back.
	// Each item yields exactly one result, so the block is idle then.
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (awaited_verdicts.size() != 0)
			@(negedge clk);
	endtask

	// Single register write; the model copy follows the same masking.
	task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_BITS-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		@(negedge clk);
		case (sel)
			REG_REFILL:  cfg_refill  = val[REFILL_BITS-1:0];
			REG_CAP:     cfg_cap     = val[CAP_BITS-1:0];
			REG_RELEASE: cfg_release = val[RELEASE_BITS-1:0];
			REG_COST:    cfg_cost    = val[COST_BITS-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// -------------------------------------------------------- result checker
	// Random stall before each result, with stretches of none at all.
	initial begin : result_side
		int       stall;
		verdict_t want;
		verdict_t got;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				rx_steady = !rx_steady;
			stall = rx_steady ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			results_seen++;
			got = m_tdata[OUT_BITS-1:0];
			if (awaited_verdicts.size() == 0) begin
				faults++;
				if (faults <= FAULT_PRINTS)
					$display("%0t: result with nothing awaited, tdata %h", $time, m_tdata);
			end else begin
				want = awaited_verdicts.pop_front();
				check_field("forward", want.forward, got.forward);
				check_field("warn", want.warn, got.warn);
				check_field("credit_level", $signed(want.credit_level),
				            $signed(got.credit_level));
				check_field("tdata pad", 0, m_tdata[8*OUT_BYTES-1:OUT_BITS]);
			end
			@(negedge clk);
		end
	end

	// -------------------------------------------------------------- stimulus
	initial begin : stimulus
		int r;
		logic [CFG_DATA_BITS-1:0] refill_v;
		logic [CFG_DATA_BITS-1:0] cap_v;
		logic [CFG_DATA_BITS-1:0] rel_v;
		logic [CFG_DATA_BITS-1:0] cost_v;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed edges
		foreach (DRILL[i]) begin
			if (DRILL[i].kind == STEP_WRITE) begin
				wait_quiet();
				write_reg(DRILL[i].sel, DRILL[i].arg[CFG_DATA_BITS-1:0]);
			end else begin
				send_stamp(DRILL[i].arg, DRILL[i].typed, DRILL[i].want);
			end
		end

		// Random phases. Each opens with a full drain, so the sender also
		// sits still until every result is in, then gets new settings.
		for (int p = 0; p < PHASES; p++) begin
			wait_quiet();
			// mostly settings where the bucket drains and refills often;
			// now and then zero or all ones on a register
			refill_v = CFG_DATA_BITS'($urandom_range(0, 40));
			cap_v    = CFG_DATA_BITS'($urandom_range(1, 600));
			cost_v   = CFG_DATA_BITS'($urandom_range(1, 60));
			case ($urandom_range(0, 7))
				0: refill_v = '0;
				1: refill_v = '1;
				default: ;
			endcase
			case ($urandom_range(0, 7))
				0: cap_v = '0;
				1: cap_v = '1;
				default: ;
			endcase
			rel_v = CFG_DATA_BITS'($urandom_range(0, cap_v));
			case ($urandom_range(0, 7))
				0: rel_v = '0;
				1: rel_v = '1;
				default: ;
			endcase
			case ($urandom_range(0, 7))
				0: cost_v = '0;
				1: cost_v = '1;
				default: ;
			endcase
			write_reg(REG_REFILL, refill_v);
			write_reg(REG_CAP, cap_v);
			write_reg(REG_RELEASE, rel_v);
			write_reg(REG_COST, cost_v);

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// mostly a clock creeping forward, with some backward steps,
				// long jumps and arbitrary stamps
				r = $urandom_range(0, 99);
				if (r < 70)
					wall = wall + $urandom_range(0, 3);
				else if (r < 80)
					wall = wall - $urandom_range(0, 40);
				else if (r < 90)
					wall = wall + $urandom;
				else
					wall = $urandom;
				send_stamp(wall, 1'b0, '0);
			end
		end

		wait_quiet();
		// two-stage pipeline, so this wait is long enough to show any stray result
		repeat (8) @(negedge clk);

		$display("Covered %0d directed rows and %0d random phases of %0d items each.",
		         DRILL_ROWS, PHASES, PHASE_ITEMS);
		$display("Sent %0d items, checked %0d results, %0d faults.",
		         items_sent, results_seen, faults);
		if (faults == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/tbll_pkg.sv
rtl/core/tbll_cfg_regs.sv
rtl/core/tbll_update.sv
rtl/core/token_bucket_log_limiter_top.sv
bench/testbench.sv
